// ----- rtl/gmd_pkg.sv -----
// Shared types, codes and helpers for the grid maze depth-first solver.
// No dependencies; the interfaces and the top level import this package.
`default_nettype none

package gmd_pkg;

   localparam int MAX_SIDE_DEFAULT = 64;

   localparam int MODE_W   = 2;
   localparam int COORD_W  = 6;
   localparam int REG_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SOLVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Cell contents as held in the store.
   localparam logic [KIND_W-1:0] K_WALL = 2'd0;
   localparam logic [KIND_W-1:0] K_FREE = 2'd1;
   localparam logic [KIND_W-1:0] K_PATH = 2'd2;
   localparam logic [KIND_W-1:0] K_DEAD = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

   localparam logic [REG_W-1:0] GRID_SIDE_RESET = 7'd64;

   // A dead end is reported as a free cell.
   function automatic logic [KIND_W-1:0] visible_kind(input logic [KIND_W-1:0] v);
      return (v == K_DEAD) ? K_FREE : v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/gmd_ifs.sv -----
// Valid/ready channel interfaces for the solver: request, response and
// register write. Depends on gmd_pkg for the field widths.
`default_nettype none

interface gmd_req_if;
   import gmd_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic               open_cell;

   modport source (output valid, mode, row, col, open_cell, input ready);
   modport sink   (input valid, mode, row, col, open_cell, output ready);
endinterface

interface gmd_rsp_if;
   import gmd_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KIND_W-1:0]   cell_kind;

   modport source (output valid, status, cell_kind, input ready);
   modport sink   (input valid, status, cell_kind, output ready);
endinterface

interface gmd_csr_if;
   import gmd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/grid_maze_depth_first_solver.sv -----
// A solve tries neighbours, backtracks from dead ends and afterwards clears the dead
// ends it marked; the microcode sequencer carries out one step per cycle and waits in
// the response step while the output is stalled. One item at a time.
// Reset clears the sequencer, the stack pointer and the output valid, and sets the
// grid to 64 by 64; the cell store is undefined until written.
`default_nettype none

module grid_maze_depth_first_solver #(
   parameter int MAX_SIDE = gmd_pkg::MAX_SIDE_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   gmd_req_if.sink    req_if,
   gmd_rsp_if.source  rsp_if,
   gmd_csr_if.sink    csr_if
);
   import gmd_pkg::*;

   // Coordinate and address widths follow from the grid side; the comparison width also covers the register width.
   localparam int SW    = $clog2(MAX_SIDE);
   localparam int AW    = 2 * SW;
   localparam int CW    = ((SW > REG_W) ? SW : REG_W) + 1;
   localparam int WW    = AW + 2;
   localparam int DEPTH = 1 << AW;
   localparam logic [AW-1:0] STACK_TOP = {AW{1'b1}};

   // Search directions in the order they are tried.
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   // Microprogram steps. The step after the response step is idle, so the
   // program counter simply rolls on from there.
   typedef enum logic [4:0] {
      S_RESP, S_IDLE, S_DISP_W, S_DISP_S, S_DISP_R, S_NOP, S_WR, S_RD, S_RD2,
      S_START, S_TRY, S_TRY2, S_TRY3, S_DEAD, S_POP1, S_POP2, S_POP3,
      S_PUSH, S_PUSH2, S_FOUND, S_MISS, S_CLR1, S_CLR2, S_CLR3
   } step_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_WRITE_REQ, OP_READ_REQ, OP_LOAD_KIND, OP_INIT,
      OP_READ_NB, OP_INC_K, OP_MARK_DEAD, OP_POP_RD, OP_POP_LD, OP_PUSH,
      OP_SET_FOUND, OP_SET_MISS, OP_DEAD_RD, OP_DEAD_WR, OP_POST
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_NO_REQ, C_MODE_WR, C_MODE_SOLVE, C_MODE_RD, C_GOAL0,
      C_NB_FREE, C_K_MORE, C_SP_ZERO, C_POPPED_LAST, C_NB_GOAL, C_DCNT_ZERO,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // The control store. Each word names one datapath action and one jump;
   // when the jump condition fails the sequencer moves to the next step.
   function automatic uword_type microcode(input step_type s);
      uword_type w;
      unique case (s)
         S_RESP:   w = '{OP_POST,      C_OUT_BUSY,    S_RESP};
         S_IDLE:   w = '{OP_ACCEPT,    C_NO_REQ,      S_IDLE};
         S_DISP_W: w = '{OP_NONE,      C_MODE_WR,     S_WR};
         S_DISP_S: w = '{OP_NONE,      C_MODE_SOLVE,  S_START};
         S_DISP_R: w = '{OP_NONE,      C_MODE_RD,     S_RD};
         S_NOP:    w = '{OP_NONE,      C_ALWAYS,      S_RESP};
         S_WR:     w = '{OP_WRITE_REQ, C_ALWAYS,      S_RESP};
         S_RD:     w = '{OP_READ_REQ,  C_NEVER,       S_IDLE};
         S_RD2:    w = '{OP_LOAD_KIND, C_ALWAYS,      S_RESP};
         S_START:  w = '{OP_INIT,      C_GOAL0,       S_FOUND};
         S_TRY:    w = '{OP_READ_NB,   C_NEVER,       S_IDLE};
         S_TRY2:   w = '{OP_NONE,      C_NB_FREE,     S_PUSH};
         S_TRY3:   w = '{OP_INC_K,     C_K_MORE,      S_TRY};
         S_DEAD:   w = '{OP_MARK_DEAD, C_SP_ZERO,     S_MISS};
         S_POP1:   w = '{OP_POP_RD,    C_NEVER,       S_IDLE};
         S_POP2:   w = '{OP_POP_LD,    C_POPPED_LAST, S_DEAD};
         S_POP3:   w = '{OP_NONE,      C_ALWAYS,      S_TRY};
         S_PUSH:   w = '{OP_PUSH,      C_NB_GOAL,     S_FOUND};
         S_PUSH2:  w = '{OP_NONE,      C_ALWAYS,      S_TRY};
         S_FOUND:  w = '{OP_SET_FOUND, C_ALWAYS,      S_CLR1};
         S_MISS:   w = '{OP_SET_MISS,  C_NEVER,       S_IDLE};
         S_CLR1:   w = '{OP_NONE,      C_DCNT_ZERO,   S_RESP};
         S_CLR2:   w = '{OP_DEAD_RD,   C_NEVER,       S_IDLE};
         S_CLR3:   w = '{OP_DEAD_WR,   C_ALWAYS,      S_CLR1};
         default:  w = '{OP_NONE,      C_ALWAYS,      S_IDLE};
      endcase
      return w;
   endfunction

   // Sequencer and control registers.
   step_type              upc_ff, upc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]         sp_ff, sp_in;
   logic [AW-1:0]         dcnt_ff, dcnt_in;
   logic [REG_W-1:0]      grid_width_ff, grid_width_in;
   logic [REG_W-1:0]      grid_height_ff, grid_height_in;

   // Datapath registers.
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [SW-1:0]         req_row_ff, req_row_in;
   logic [SW-1:0]         req_col_ff, req_col_in;
   logic                  open_ff, open_in;
   logic                  inside_ff, inside_in;
   logic [SW-1:0]         cur_row_ff, cur_row_in;
   logic [SW-1:0]         cur_col_ff, cur_col_in;
   logic [1:0]            k_ff, k_in;
   logic [SW-1:0]         nb_row_ff, nb_row_in;
   logic [SW-1:0]         nb_col_ff, nb_col_in;
   logic                  nb_ok_ff, nb_ok_in;
   logic [STATUS_W-1:0]   st_ff, st_in;
   logic [KIND_W-1:0]     kd_ff, kd_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   // Cell store and walk stack. The walk stack grows upwards from address
   // zero; the list of dead ends to clear grows downwards from the top of the
   // same memory. Together they never hold more entries than cells visited.
   logic [KIND_W-1:0]     cell_store [DEPTH];
   logic [WW-1:0]         walk_stack [DEPTH];
   logic [KIND_W-1:0]     cell_rd_ff;
   logic [WW-1:0]         stk_rd_ff;

   logic                  cell_we;
   logic [AW-1:0]         cell_waddr;
   logic [KIND_W-1:0]     cell_wdata;
   logic [AW-1:0]         cell_raddr;
   logic                  stk_we;
   logic [AW-1:0]         stk_waddr;
   logic [WW-1:0]         stk_wdata;
   logic [AW-1:0]         stk_raddr;

   uword_type             uw;
   logic                  cond_hit;
   logic                  out_busy;
   logic [CW-1:0]         w_eff, h_eff;
   logic                  at_goal_nb;
   logic                  nb_ok_c;
   logic [SW-1:0]         nb_row_c, nb_col_c;
   logic                  req_inside_c;

   // Register values outside the legal range are clamped to 1 .. MAX_SIDE.
   always_comb begin
      w_eff = CW'(grid_width_ff);
      h_eff = CW'(grid_height_ff);
      if (w_eff == '0) begin
         w_eff = CW'(1);
      end else if (w_eff > CW'(MAX_SIDE)) begin
         w_eff = CW'(MAX_SIDE);
      end
      if (h_eff == '0) begin
         h_eff = CW'(1);
      end else if (h_eff > CW'(MAX_SIDE)) begin
         h_eff = CW'(MAX_SIDE);
      end
   end

   // Neighbour of the current cell in the direction now being tried, and
   // whether it lies inside the grid in use.
   always_comb begin
      nb_row_c = cur_row_ff;
      nb_col_c = cur_col_ff;
      unique case (k_ff)
         DIR_RIGHT: begin
            nb_ok_c  = (CW'(cur_col_ff) + CW'(1)) < w_eff;
            nb_col_c = cur_col_ff + SW'(1);
         end
         DIR_DOWN: begin
            nb_ok_c  = (CW'(cur_row_ff) + CW'(1)) < h_eff;
            nb_row_c = cur_row_ff + SW'(1);
         end
         DIR_LEFT: begin
            nb_ok_c  = (cur_col_ff != '0);
            nb_col_c = cur_col_ff - SW'(1);
         end
         DIR_UP: begin
            nb_ok_c  = (cur_row_ff != '0);
            nb_row_c = cur_row_ff - SW'(1);
         end
         default: begin
            nb_ok_c = 1'b0;
         end
      endcase
   end

   assign at_goal_nb = (CW'(nb_row_ff) == (h_eff - CW'(1))) &&
                       (CW'(nb_col_ff) == (w_eff - CW'(1)));

   assign req_inside_c = (CW'(req_if.row) < CW'(MAX_SIDE)) &&
                         (CW'(req_if.col) < CW'(MAX_SIDE));

   assign out_busy = rsp_valid_ff && !rsp_if.ready;

   // Datapath actions of the current control word.
   always_comb begin
      uw = microcode(upc_ff);

      mode_in        = mode_ff;
      req_row_in     = req_row_ff;
      req_col_in     = req_col_ff;
      open_in        = open_ff;
      inside_in      = inside_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      k_in           = k_ff;
      nb_row_in      = nb_row_ff;
      nb_col_in      = nb_col_ff;
      nb_ok_in       = nb_ok_ff;
      st_in          = st_ff;
      kd_in          = kd_ff;
      sp_in          = sp_ff;
      dcnt_in        = dcnt_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_valid_in   = out_busy;

      cell_we    = 1'b0;
      cell_waddr = {cur_row_ff, cur_col_ff};
      cell_wdata = K_PATH;
      cell_raddr = {nb_row_c, nb_col_c};
      stk_we     = 1'b0;
      stk_waddr  = sp_ff;
      stk_wdata  = {cur_row_ff, cur_col_ff, k_ff};
      stk_raddr  = sp_ff - AW'(1);

      unique case (uw.op)
         OP_NONE: begin
         end
         OP_ACCEPT: begin
            if (req_if.valid) begin
               mode_in    = req_if.mode;
               req_row_in = SW'(req_if.row);
               req_col_in = SW'(req_if.col);
               open_in    = req_if.open_cell;
               inside_in  = req_inside_c;
               st_in      = ST_DONE;
               kd_in      = K_WALL;
            end
         end
         OP_WRITE_REQ: begin
            cell_we    = inside_ff;
            cell_waddr = {req_row_ff, req_col_ff};
            cell_wdata = open_ff ? K_FREE : K_WALL;
         end
         OP_READ_REQ: begin
            cell_raddr = {req_row_ff, req_col_ff};
         end
         OP_LOAD_KIND: begin
            kd_in = inside_ff ? visible_kind(cell_rd_ff) : K_WALL;
         end
         OP_INIT: begin
            // The start cell is taken onto the path whatever it holds.
            cur_row_in = '0;
            cur_col_in = '0;
            k_in       = DIR_RIGHT;
            sp_in      = '0;
            dcnt_in    = '0;
            cell_we    = 1'b1;
            cell_waddr = '0;
            cell_wdata = K_PATH;
         end
         OP_READ_NB: begin
            nb_row_in = nb_row_c;
            nb_col_in = nb_col_c;
            nb_ok_in  = nb_ok_c;
         end
         OP_INC_K: begin
            k_in = k_ff + 2'd1;
         end
         OP_MARK_DEAD: begin
            cell_we    = 1'b1;
            cell_wdata = K_DEAD;
            stk_we     = 1'b1;
            stk_waddr  = STACK_TOP - dcnt_ff;
            stk_wdata  = {cur_row_ff, cur_col_ff, 2'b00};
            dcnt_in    = dcnt_ff + AW'(1);
         end
         OP_POP_RD: begin
            sp_in = sp_ff - AW'(1);
         end
         OP_POP_LD: begin
            {cur_row_in, cur_col_in} = stk_rd_ff[WW-1:2];
            k_in = stk_rd_ff[1:0] + 2'd1;
         end
         OP_PUSH: begin
            stk_we     = 1'b1;
            sp_in      = sp_ff + AW'(1);
            cur_row_in = nb_row_ff;
            cur_col_in = nb_col_ff;
            k_in       = DIR_RIGHT;
            cell_we    = 1'b1;
            cell_waddr = {nb_row_ff, nb_col_ff};
            cell_wdata = K_PATH;
         end
         OP_SET_FOUND: begin
            st_in = ST_FOUND;
         end
         OP_SET_MISS: begin
            st_in = ST_NONE;
         end
         OP_DEAD_RD: begin
            stk_raddr = STACK_TOP - dcnt_ff + AW'(1);
            dcnt_in   = dcnt_ff - AW'(1);
         end
         OP_DEAD_WR: begin
            cell_we    = 1'b1;
            cell_waddr = stk_rd_ff[WW-1:2];
            cell_wdata = K_FREE;
         end
         OP_POST: begin
            if (!out_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_kind_in   = kd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Jump condition and next step.
   always_comb begin
      unique case (uw.cond)
         C_NEVER:       cond_hit = 1'b0;
         C_ALWAYS:      cond_hit = 1'b1;
         C_NO_REQ:      cond_hit = !req_if.valid;
         C_MODE_WR:     cond_hit = (mode_ff == MODE_WRITE);
         C_MODE_SOLVE:  cond_hit = (mode_ff == MODE_SOLVE);
         C_MODE_RD:     cond_hit = (mode_ff == MODE_READ);
         C_GOAL0:       cond_hit = (w_eff == CW'(1)) && (h_eff == CW'(1));
         C_NB_FREE:     cond_hit = nb_ok_ff && (cell_rd_ff == K_FREE);
         C_K_MORE:      cond_hit = (k_ff != DIR_UP);
         C_SP_ZERO:     cond_hit = (sp_ff == '0);
         C_POPPED_LAST: cond_hit = (stk_rd_ff[1:0] == DIR_UP);
         C_NB_GOAL:     cond_hit = at_goal_nb;
         C_DCNT_ZERO:   cond_hit = (dcnt_ff == '0);
         C_OUT_BUSY:    cond_hit = out_busy;
         default:       cond_hit = 1'b1;
      endcase
      upc_in = cond_hit ? uw.target : step_type'(5'(upc_ff + 5'd1));
   end

   // Register writes, always ready; user writes only while idle, not enforced.
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_if.valid) begin
         if (csr_if.index == REG_GRID_WIDTH) begin
            grid_width_in = csr_if.wdata;
         end else if (csr_if.index == REG_GRID_HEIGHT) begin
            grid_height_in = csr_if.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_in_unused_guard: begin
      end
      mode_ff       <= mode_in;
      req_row_ff    <= req_row_in;
      req_col_ff    <= req_col_in;
      open_ff       <= open_in;
      inside_ff     <= inside_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      k_ff          <= k_in;
      nb_row_ff     <= nb_row_in;
      nb_col_ff     <= nb_col_in;
      nb_ok_ff      <= nb_ok_in;
      st_ff         <= st_in;
      kd_ff         <= kd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      if (reset) begin
         upc_ff         <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         sp_ff          <= '0;
         dcnt_ff        <= '0;
         grid_width_ff  <= GRID_SIDE_RESET;
         grid_height_ff <= GRID_SIDE_RESET;
      end else begin
         upc_ff         <= upc_in;
         rsp_valid_ff   <= rsp_valid_in;
         sp_ff          <= sp_in;
         dcnt_ff        <= dcnt_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_store[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_store[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         walk_stack[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= walk_stack[stk_raddr];
   end

   assign req_if.ready     = (upc_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.cell_kind = rsp_kind_ff;
   assign csr_if.ready     = 1'b1;

   // The walk stack and the dead-end list never run into each other.
   a_stack_room: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, sp_ff} + {1'b0, dcnt_ff}) <= {1'b0, STACK_TOP})
      else $error("walk stack and dead-end list overlap");

   // A path is reported only with the walk standing on the goal cell.
   a_found_at_goal: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_FOUND) |->
         ((CW'(cur_row_ff) == (h_eff - CW'(1))) && (CW'(cur_col_ff) == (w_eff - CW'(1)))))
      else $error("path reported away from the goal cell");

   // A step onto a neighbour needs that neighbour inside the grid.
   a_push_inside: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_PUSH) |-> nb_ok_ff)
      else $error("walk stepped outside the grid");

   // A result appears only from the response step.
   a_post_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff == S_RESP))
      else $error("result posted outside the response step");

endmodule

`default_nettype wire
